[sv/mlfq_pkg.sv]
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam int MaxProcesses = 16;
    localparam int MaxLevels    = 4;
    localparam int CfgWidth     = 16;
    localparam int CfgIdxWidth  = 3;

    typedef enum logic [2:0] {
        CMD_ARRIVAL  = 3'd0,
        CMD_DISPATCH = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_EXPIRE   = 3'd3,
        CMD_QUERY    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_LEVELS  = 3'd0,
        CFG_BOOST   = 3'd1,
        CFG_QUANT0  = 3'd2,
        CFG_QUANT1  = 3'd3,
        CFG_QUANT2  = 3'd4,
        CFG_QUANT3  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LVL_RD,
        ST_LVL_WAIT,
        ST_EXEC,
        ST_POP_WAIT,
        ST_POP_LVL,
        ST_POP_LVL_WAIT,
        ST_BOOST_SCAN,
        ST_BOOST_WAIT,
        ST_BOOST_PUSH,
        ST_RUN_RD,
        ST_RUN_WAIT,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  process_id;
        logic [31:0] tick_number;
        logic [3:0]  running_process;
        logic        running_valid;
        logic [15:0] quantum_used;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] chosen_process;
        logic       chosen_valid;
        logic       preempt;
        logic       boosted;
        logic [1:0] process_level;
    } t_out_beat;

    // remainder control between sequencer and divider
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic zero_rem;
    } t_div_rsp;

endpackage

[sv/mlfq_div.sv]
`timescale 1ns / 1ps
// restoring remainder unit, one quotient bit per cycle
module mlfq_div
    import mlfq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output t_div_rsp    o_rsp
);

    logic [31:0] r_num, n_num;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [16:0] w_shift;

    // next remainder step
    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_shift = {r_rem[15:0], r_num[31]};
        if (i_req.start) begin
            n_num  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            n_rem = (w_shift >= {1'b0, r_den}) ? w_shift - {1'b0, r_den} : w_shift;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.zero_rem = (r_rem == '0);

endmodule

[sv/multilevel_feedback_queue_scheduler.sv]
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler. A command is taken when start is high and
// busy is low; its one result appears on o_result for a single cycle marked by
// o_done and must be taken then, since the receiver cannot stall. Arrival, expiry
// and query read the level memory; dispatch reads the queue memory and then the
// level memory of the popped process. A tick with a nonzero tick number and boost
// interval first runs a serial remainder against the boost interval; a boosting
// tick then moves each queued entry of levels one and up to level zero. The next
// command can be taken at the edge that takes the result.
// No clearing pass is needed after reset.
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
#(
    parameter int MAX_PROCESSES = MaxProcesses,
    parameter int MAX_LEVELS    = MaxLevels
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  t_in_beat               i_cmd,
    output logic                   busy,
    output logic                   o_done,
    output t_out_beat              o_result,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [CfgWidth-1:0]    i_cfg_data
);

    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int SW = LW + PW;

    // next ring index with wrap at the queue depth
    function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] v);
        next_idx = (v == PW'(MAX_PROCESSES - 1)) ? '0 : v + PW'(1);
    endfunction

    // configuration
    logic [2:0]  r_levels;
    logic [15:0] r_boost_int;
    logic [15:0] r_quant [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= 3'd3;
            r_boost_int <= 16'd100;
            r_quant[0]  <= 16'd2;
            r_quant[1]  <= 16'd4;
            r_quant[2]  <= 16'd8;
            r_quant[3]  <= 16'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVELS: r_levels    <= i_cfg_data[2:0];
                CFG_BOOST:  r_boost_int <= i_cfg_data;
                CFG_QUANT0: r_quant[0]  <= i_cfg_data;
                CFG_QUANT1: r_quant[1]  <= i_cfg_data;
                CFG_QUANT2: r_quant[2]  <= i_cfg_data;
                CFG_QUANT3: r_quant[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last level in use
    logic [2:0] w_used;
    logic [2:0] w_last;
    always_comb begin
        w_used = r_levels;
        if (w_used == 3'd0) w_used = 3'd1;
        if (w_used > 3'(MAX_LEVELS)) w_used = 3'(MAX_LEVELS);
        w_last = w_used - 3'd1;
    end

    // memories
    logic [1:0]    m_lvl [MAX_PROCESSES];
    logic [PW-1:0] m_slot [MAX_LEVELS << PW];
    logic          w_lvl_we;
    logic [PW-1:0] w_lvl_wa, w_lvl_ra;
    logic [1:0]    w_lvl_wd;
    logic [1:0]    r_lvl_q;
    logic          w_slot_we;
    logic [SW-1:0] w_slot_wa, w_slot_ra;
    logic [PW-1:0] w_slot_wd;
    logic [PW-1:0] r_slot_q;

    always_ff @(posedge i_clk) begin
        if (w_lvl_we) m_lvl[w_lvl_wa] <= w_lvl_wd;
        r_lvl_q <= m_lvl[w_lvl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) m_slot[w_slot_wa] <= w_slot_wd;
        r_slot_q <= m_slot[w_slot_ra];
    end

    // queue pointers
    logic [PW-1:0] r_head [MAX_LEVELS], n_head [MAX_LEVELS];
    logic [PW-1:0] r_tail [MAX_LEVELS], n_tail [MAX_LEVELS];
    logic [CW-1:0] r_count [MAX_LEVELS], n_count [MAX_LEVELS];

    t_state    r_state, n_state;
    t_in_beat  r_cmd, n_cmd;
    logic [1:0] r_lvl, n_lvl;
    logic [LW-1:0] r_scan, n_scan;
    logic       r_boost, n_boost;
    t_out_beat  r_res, n_res;
    logic       r_done, n_done;
    t_div_req   w_div_req;
    t_div_rsp   w_div_rsp;

    mlfq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (r_cmd.tick_number),
        .i_divisor  (r_boost_int),
        .o_rsp      (w_div_rsp)
    );

    logic w_pid_ok, w_run_ok;
    logic [LW-1:0] w_first;
    logic          w_any;
    logic [LW-1:0] w_dst;
    logic [2:0]    w_cur;
    assign w_pid_ok = (9'(r_cmd.process_id) < 9'(MAX_PROCESSES));
    assign w_run_ok = r_cmd.running_valid &&
                      (9'(r_cmd.running_process) < 9'(MAX_PROCESSES));

    // highest-priority (lowest-numbered) non-empty level
    always_comb begin
        w_first = '0;
        w_any   = 1'b0;
        for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                w_first = LW'(l);
                w_any   = 1'b1;
            end
        end
    end

    // non-empty level among one and up
    logic [LW-1:0] w_bfirst;
    logic          w_bany;
    always_comb begin
        w_bfirst = '0;
        w_bany   = 1'b0;
        for (int l = MAX_LEVELS - 1; l >= 1; l--) begin
            if (r_count[l] != '0) begin
                w_bfirst = LW'(l);
                w_bany   = 1'b1;
            end
        end
    end

    always_comb begin
        w_cur = {1'b0, r_lvl_q};
        w_dst = (w_cur < w_last) ? LW'(w_cur + 3'd1) : LW'(w_last);
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_lvl     = r_lvl;
        n_scan    = r_scan;
        n_boost   = r_boost;
        n_res     = r_res;
        n_done    = 1'b0;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        w_lvl_we  = 1'b0;
        w_lvl_wa  = PW'(r_cmd.process_id);
        w_lvl_wd  = '0;
        w_lvl_ra  = PW'(r_cmd.process_id);
        w_slot_we = 1'b0;
        w_slot_wa = '0;
        w_slot_wd = PW'(r_cmd.process_id);
        w_slot_ra = {r_scan, r_head[r_scan]};
        w_div_req.start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_res   = '0;
                    n_boost = 1'b0;
                    n_state = ST_LVL_RD;
                end
            end
            ST_LVL_RD: begin
                n_res.chosen_process = r_cmd.process_id;
                priority case (r_cmd.command)
                    CMD_ARRIVAL, CMD_EXPIRE, CMD_QUERY: begin
                        n_state = w_pid_ok ? ST_LVL_WAIT : ST_DONE;
                    end
                    CMD_DISPATCH: begin
                        n_res.chosen_process = '0;
                        if (w_any) begin
                            n_scan  = w_first;
                            n_state = ST_POP_WAIT;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    CMD_TICK: begin
                        n_res.chosen_process = '0;
                        if (r_cmd.tick_number != '0 && r_boost_int != '0) begin
                            w_div_req.start = 1'b1;
                            n_state = ST_DIV;
                        end else begin
                            n_state = ST_RUN_RD;
                        end
                    end
                    default: begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_LVL_WAIT: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                priority case (r_cmd.command)
                    CMD_ARRIVAL, CMD_EXPIRE: begin
                        n_lvl = (r_cmd.command == CMD_ARRIVAL) ? 2'd0 : 2'(w_dst);
                        n_res.process_level = n_lvl;
                        w_lvl_we = 1'b1;
                        w_lvl_wd = n_lvl;
                        if (r_count[n_lvl[LW-1:0]] < CW'(MAX_PROCESSES)) begin
                            w_slot_we = 1'b1;
                            w_slot_wa = {n_lvl[LW-1:0], r_tail[n_lvl[LW-1:0]]};
                            n_tail[n_lvl[LW-1:0]] = next_idx(r_tail[n_lvl[LW-1:0]]);
                            n_count[n_lvl[LW-1:0]] = r_count[n_lvl[LW-1:0]] + CW'(1);
                        end
                    end
                    default: begin
                        n_res.process_level = r_lvl_q;
                        n_res.preempt = (r_cmd.quantum_used >= r_quant[r_lvl_q]);
                    end
                endcase
                n_state = ST_DONE;
            end
            ST_POP_WAIT: begin
                n_head[r_scan] = next_idx(r_head[r_scan]);
                n_count[r_scan] = r_count[r_scan] - CW'(1);
                n_state = ST_POP_LVL;
            end
            ST_POP_LVL: begin
                n_res.chosen_process = 4'(r_slot_q);
                n_res.chosen_valid   = 1'b1;
                w_lvl_ra = r_slot_q;
                n_state  = ST_POP_LVL_WAIT;
            end
            ST_POP_LVL_WAIT: begin
                n_res.process_level = r_lvl_q;
                n_state = ST_DONE;
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.zero_rem) begin
                        n_boost = 1'b1;
                        n_res.boosted = 1'b1;
                        n_state = ST_BOOST_SCAN;
                    end else begin
                        n_state = ST_RUN_RD;
                    end
                end
            end
            ST_BOOST_SCAN: begin
                if (w_bany) begin
                    n_scan  = w_bfirst;
                    n_state = ST_BOOST_WAIT;
                end else begin
                    n_state = ST_RUN_RD;
                end
            end
            ST_BOOST_WAIT: begin
                n_head[r_scan] = next_idx(r_head[r_scan]);
                n_count[r_scan] = r_count[r_scan] - CW'(1);
                n_state = ST_BOOST_PUSH;
            end
            ST_BOOST_PUSH: begin
                w_lvl_we = 1'b1;
                w_lvl_wa = r_slot_q;
                w_lvl_wd = 2'd0;
                if (r_count[0] < CW'(MAX_PROCESSES)) begin
                    w_slot_we = 1'b1;
                    w_slot_wa = {LW'(0), r_tail[0]};
                    w_slot_wd = r_slot_q;
                    n_tail[0] = next_idx(r_tail[0]);
                    n_count[0] = r_count[0] + CW'(1);
                end
                n_state = ST_BOOST_SCAN;
            end
            ST_RUN_RD: begin
                w_lvl_ra = PW'(r_cmd.running_process);
                if (w_run_ok) begin
                    n_res.chosen_process = r_cmd.running_process;
                    if (r_boost) begin
                        w_lvl_we = 1'b1;
                        w_lvl_wa = PW'(r_cmd.running_process);
                        w_lvl_wd = 2'd0;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_RUN_WAIT;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RUN_WAIT: begin
                n_res.process_level = r_lvl_q;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
        r_cmd   <= n_cmd;
        r_lvl   <= n_lvl;
        r_scan  <= n_scan;
        r_boost <= n_boost;
        r_res   <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[dv/tb_multilevel_feedback_queue_scheduler.sv]
`timescale 1ns / 1ps
module tb_multilevel_feedback_queue_scheduler;
    import mlfq_pkg::*;

    localparam int StallLimit = 4000;
    localparam int Settle     = 16;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    t_in_beat               i_cmd = '0;
    logic                   busy;
    logic                   o_done;
    t_out_beat              o_result;
    logic                   i_cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] i_cfg_idx = '0;
    logic [CfgWidth-1:0]    i_cfg_data = '0;

    multilevel_feedback_queue_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_cmd),
        .busy(busy), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // scheduler shadow state
    logic [2:0]  sh_levels = 3'd3;
    logic [15:0] sh_boost = 16'd100;
    logic [15:0] sh_quant [4] = '{16'd2, 16'd4, 16'd8, 16'd16};
    logic [1:0]  sh_level [16];
    logic [3:0]  sh_fifo [4][$];
    logic [15:0] seen = '0;

    t_out_beat   pending_results [$];
    int          errors = 0;
    int          idle_pct = 0;
    int          quiet = 0;

    // compute one result and advance the shadow state
    function automatic t_out_beat schedule(input t_in_beat b);
        t_out_beat r;
        int last;
        logic [3:0] p;
        r = '0;
        case (b.command)
            CMD_ARRIVAL: begin
                r.chosen_process = b.process_id;
                sh_level[b.process_id] = 2'd0;
                if (sh_fifo[0].size() < MaxProcesses) sh_fifo[0].push_back(b.process_id);
            end
            CMD_DISPATCH: begin
                for (int l = 0; l < MaxLevels; l++) begin
                    if (sh_fifo[l].size() != 0) begin
                        r.chosen_process = sh_fifo[l].pop_front();
                        r.chosen_valid = 1'b1;
                        r.process_level = sh_level[r.chosen_process];
                        break;
                    end
                end
            end
            CMD_TICK: begin
                if (b.tick_number != 0 && sh_boost != 0 && b.tick_number % sh_boost == 0) begin
                    r.boosted = 1'b1;
                    for (int l = 1; l < MaxLevels; l++) begin
                        while (sh_fifo[l].size() != 0) begin
                            p = sh_fifo[l].pop_front();
                            sh_level[p] = 2'd0;
                            if (sh_fifo[0].size() < MaxProcesses) sh_fifo[0].push_back(p);
                        end
                    end
                    if (b.running_valid) sh_level[b.running_process] = 2'd0;
                end
                if (b.running_valid) begin
                    r.chosen_process = b.running_process;
                    r.process_level = sh_level[b.running_process];
                end
            end
            CMD_EXPIRE: begin
                last = (sh_levels == 0) ? 0 : (sh_levels > MaxLevels) ? MaxLevels - 1
                     : sh_levels - 1;
                p = b.process_id;
                sh_level[p] = (sh_level[p] < last) ? sh_level[p] + 2'd1 : 2'(last);
                if (sh_fifo[sh_level[p]].size() < MaxProcesses)
                    sh_fifo[sh_level[p]].push_back(p);
                r.chosen_process = p;
                r.process_level = sh_level[p];
            end
            CMD_QUERY: begin
                r.chosen_process = b.process_id;
                r.process_level = sh_level[b.process_id];
                r.preempt = b.quantum_used >= sh_quant[sh_level[b.process_id]];
            end
            default: ;
        endcase
        return r;
    endfunction

    // result of a beat without touching the shadow state
    function automatic t_out_beat schedule_peek(input t_in_beat b);
        logic [1:0] lv_save [16];
        logic [3:0] fifo_save [4][$];
        t_out_beat r;
        lv_save = sh_level;
        fifo_save = sh_fifo;
        r = schedule(b);
        sh_level = lv_save;
        sh_fifo = fifo_save;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want) begin
                    $display("%0t mismatch expected %h actual %h", $time, want, o_result);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // send one command beat, then maybe idle
    task automatic issue(input t_in_beat b);
        start <= 1'b1;
        i_cmd <= b;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(schedule(b));
        if (b.command == CMD_ARRIVAL) seen[b.process_id] = 1'b1;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    // one register write; the caller drops the write enable after the last one
    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_LEVELS: sh_levels = data[2:0];
            CFG_BOOST:  sh_boost = data;
            CFG_QUANT0: sh_quant[0] = data;
            CFG_QUANT1: sh_quant[1] = data;
            CFG_QUANT2: sh_quant[2] = data;
            CFG_QUANT3: sh_quant[3] = data;
            default: ;
        endcase
    endtask

    function automatic logic [3:0] known_pid();
        logic [3:0] p;
        do p = 4'($urandom_range(15)); while (!seen[p]);
        return p;
    endfunction

    // mostly legal traffic with random content
    function automatic t_in_beat random_beat();
        t_in_beat b;
        int pick;
        b = t_in_beat'({$urandom(), $urandom(), $urandom()});
        pick = $urandom_range(99);
        if (seen == 0 || pick < 30) b.command = CMD_ARRIVAL;
        else if (pick < 52) b.command = CMD_DISPATCH;
        else if (pick < 67) b.command = CMD_TICK;
        else if (pick < 82) b.command = CMD_EXPIRE;
        else if (pick < 96) b.command = CMD_QUERY;
        else b.command = 3'(CMD_QUERY) + 3'($urandom_range(1, 3));
        if (b.command == CMD_EXPIRE || b.command == CMD_QUERY) b.process_id = known_pid();
        if (b.command == CMD_TICK) begin
            if (b.running_valid) b.running_process = known_pid();
            if (sh_boost != 0 && $urandom_range(1)) b.tick_number = sh_boost * $urandom_range(1, 9);
        end
        if ($urandom_range(3) == 0) b.quantum_used = sh_quant[$urandom_range(3)] - 16'($urandom_range(1));
        return b;
    endfunction

    typedef struct {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_row;

    t_row rows [$];

    task automatic add_row(input logic [2:0] cmd, input logic [3:0] pid, input logic [31:0] tick,
                           input logic [3:0] run, input logic run_ok, input logic [15:0] used,
                           input logic typed, input t_out_beat want);
        rows.push_back('{'{cmd, pid, tick, run, run_ok, used}, typed, want});
    endtask

    initial begin
        t_out_beat got;
        logic [2:0]  lv_set [6] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3};
        logic [15:0] bi_set [6] = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd3, 16'd100};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset defaults
        add_row(CMD_DISPATCH, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 2'd0});
        add_row(CMD_ARRIVAL, 4'd15, 32'd0, 4'd0, 1'b0, 16'd0, 1'b1, '{4'd15, 1'b0, 1'b0, 1'b0, 2'd0});
        add_row(CMD_ARRIVAL, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 2'd0});
        add_row(CMD_EXPIRE, 4'd15, 32'd0, 4'd0, 1'b0, 16'd0, 1'b1, '{4'd15, 1'b0, 1'b0, 1'b0, 2'd1});
        add_row(CMD_EXPIRE, 4'd15, 32'd0, 4'd0, 1'b0, 16'd0, 1'b1, '{4'd15, 1'b0, 1'b0, 1'b0, 2'd2});
        // expiry at the last level in use stays there
        add_row(CMD_EXPIRE, 4'd15, 32'd0, 4'd0, 1'b0, 16'd0, 1'b1, '{4'd15, 1'b0, 1'b0, 1'b0, 2'd2});
        add_row(CMD_QUERY, 4'd15, 32'd0, 4'd0, 1'b0, 16'd8, 1'b1, '{4'd15, 1'b0, 1'b1, 1'b0, 2'd2});
        add_row(CMD_QUERY, 4'd15, 32'd0, 4'd0, 1'b0, 16'd7, 1'b1, '{4'd15, 1'b0, 1'b0, 1'b0, 2'd2});
        add_row(CMD_QUERY, 4'd0, 32'd0, 4'd0, 1'b0, 16'hffff, 1'b1, '{4'd0, 1'b0, 1'b1, 1'b0, 2'd0});
        add_row(CMD_QUERY, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b0, 2'd0});
        // tick zero never boosts
        add_row(CMD_TICK, 4'd0, 32'd0, 4'd15, 1'b1, 16'd0, 1'b1, '{4'd15, 1'b0, 1'b0, 1'b0, 2'd2});
        add_row(CMD_TICK, 4'd0, 32'd100, 4'd0, 1'b1, 16'd0, 1'b1, '{4'd0, 1'b0, 1'b0, 1'b1, 2'd0});
        add_row(CMD_TICK, 4'd15, 32'hffffffff, 4'd15, 1'b0, 16'hffff, 1'b1, '0);
        add_row(CMD_DISPATCH, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, '0);
        add_row(CMD_DISPATCH, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, '0);
        add_row(CMD_DISPATCH, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, '0);
        add_row(CMD_DISPATCH, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0, 1'b0, '0);
        // unused opcodes leave state alone and return zeros
        for (int k = 1; k <= 3; k++)
            add_row(3'(CMD_QUERY) + 3'(k), 4'hf, 32'hffffffff, 4'hf, 1'b1, 16'hffff, 1'b1, '0);

        foreach (rows[i]) begin
            got = schedule_peek(rows[i].beat);
            if (rows[i].typed && got !== rows[i].want) begin
                $display("%0t table row %0d expected %h actual %h", $time, i, rows[i].want, got);
                errors++;
            end
            issue(rows[i].beat);
        end

        // full queue: pushes past sixteen entries in level zero are dropped
        for (int k = 0; k < 17; k++)
            issue('{CMD_ARRIVAL, 4'(k), 32'd0, 4'd0, 1'b0, 16'd0});
        for (int k = 0; k < 17; k++)
            issue('{CMD_DISPATCH, 4'd0, 32'd0, 4'd0, 1'b0, 16'd0});
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_LEVELS, 16'(lv_set[ph]));
            cfg_write(CFG_BOOST, bi_set[ph]);
            cfg_write(CFG_QUANT0, ph == 0 ? 16'd1 : 16'($urandom_range(1, 65535)));
            cfg_write(CFG_QUANT1, ph == 1 ? 16'hffff : 16'($urandom_range(1, 40)));
            cfg_write(CFG_QUANT2, ph == 2 ? 16'd1 : 16'($urandom_range(1, 40)));
            cfg_write(CFG_QUANT3, ph == 3 ? 16'hffff : 16'($urandom_range(1, 40)));
            i_cfg_we <= 1'b0;
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 45;
                2: idle_pct = 0;
                default: idle_pct = 28;
            endcase
            for (int n = 0; n < 88; n++) begin
                issue(random_beat());
                if (n == 44 && ph == 1) begin
                    start <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/mlfq_pkg.sv
sv/mlfq_div.sv
sv/multilevel_feedback_queue_scheduler.sv
dv/tb_multilevel_feedback_queue_scheduler.sv
